>>> rtl/core/flux_delta_code_encoder_core_assert.svh
`ifndef FLUX_DELTA_CODE_ENCODER_CORE_ASSERT_SVH
`define FLUX_DELTA_CODE_ENCODER_CORE_ASSERT_SVH

// check a property outside reset
`define FDCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define FDCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fdce_pkg.sv
package fdce_pkg;

  localparam int POS_WIDTH_DEF = 32;

  localparam logic [31:0] LIM_1B = 32'h0000_0080;
  localparam logic [31:0] LIM_2B = 32'h0000_4000;
  localparam logic [31:0] LIM_3B = 32'h0020_0000;
  localparam logic [31:0] LIM_4B = 32'h1000_0000;

  localparam logic [7:0] PFX_2B  = 8'h80;
  localparam logic [7:0] PFX_3B  = 8'hC0;
  localparam logic [7:0] PFX_4B  = 8'hE0;
  localparam logic [31:0] CODE_SAT = {PFX_4B | 8'h0F, 8'hFF, 8'hFF, 8'hFF};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  last_idx;
  } code_t;

endpackage

>>> rtl/core/fdce_delta_code.sv
module fdce_delta_code
  import fdce_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  logic [POSITION_WIDTH-1:0] pos,
  input  logic [POSITION_WIDTH-1:0] last_pos,
  output code_t                     code
);

  logic [POSITION_WIDTH-1:0] delta;
  logic [31:0]               d32;

  assign delta = pos - last_pos;
  assign d32   = 32'(delta);

  always_comb begin
    if (d32 < LIM_1B) begin
      code.bytes    = {24'h0, d32[7:0]};
      code.last_idx = 2'd0;
    end else if (d32 < LIM_2B) begin
      code.bytes    = {16'h0, PFX_2B | d32[15:8], d32[7:0]};
      code.last_idx = 2'd1;
    end else if (d32 < LIM_3B) begin
      code.bytes    = {8'h0, PFX_3B | d32[23:16], d32[15:0]};
      code.last_idx = 2'd2;
    end else if (d32 < LIM_4B) begin
      code.bytes    = {PFX_4B | d32[31:24], d32[23:0]};
      code.last_idx = 2'd3;
    end else begin
      code.bytes    = CODE_SAT;
      code.last_idx = 2'd3;
    end
  end

endmodule

>>> rtl/core/flux_delta_code_encoder_core.sv
// Flux delta code encoder. Each accepted flux word is scanned one bit per
// clock while no pulse's code is being emitted, most significant bit first,
// by a single position counter and one shared subtract-and-compare unit;
// scanning stops after the word's last pulse. Each pulse then spends one
// clock per code byte (one to four) in the output register, longer if
// out_ready is low. A word therefore passes through an accept step, its scan
// and its code bytes, and in_ready stays low until the word is finished. A
// word without pulses yields no bytes. A final result byte may still wait in
// the output register while the next word is taken.
module flux_delta_code_encoder_core
  import fdce_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_flux_word,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_code_byte,
  output logic        out_code_end,
  output logic        out_last_of_run
);

  `include "flux_delta_code_encoder_core_assert.svh"

  state_t                    state_r, state_nxt;
  logic [15:0]               word_r, word_nxt;
  logic [POSITION_WIDTH-1:0] bit_pos_r, bit_pos_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [POSITION_WIDTH-1:0] last_r, last_nxt;
  logic [31:0]               code_r, code_nxt;
  logic [1:0]                rem_r, rem_nxt;
  logic                      more_r, more_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      end_r, end_nxt;
  logic                      lor_r, lor_nxt;
  logic [POSITION_WIDTH-1:0] start_pos;
  logic                      out_free;
  code_t                     code;

  fdce_delta_code #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_delta_code (
    .pos      (pos_r),
    .last_pos (last_r),
    .code     (code)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_code_byte   = byte_r;
  assign out_code_end    = end_r;
  assign out_last_of_run = lor_r;
  assign out_free        = !out_valid_r || out_ready;
  assign start_pos       = in_track_start ? '0 : bit_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_pos_r   <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_pos_r   <= bit_pos_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pos_r  <= pos_nxt;
    code_r <= code_nxt;
    rem_r  <= rem_nxt;
    more_r <= more_nxt;
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    lor_r  <= lor_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    bit_pos_nxt   = bit_pos_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    code_nxt      = code_r;
    rem_nxt       = rem_r;
    more_nxt      = more_r;
    byte_nxt      = byte_r;
    end_nxt       = end_r;
    lor_nxt       = lor_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt    = in_flux_word;
          pos_nxt     = start_pos;
          last_nxt    = in_track_start ? '0 : last_r;
          bit_pos_nxt = start_pos + POSITION_WIDTH'(16);
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        word_nxt = {word_r[14:0], 1'b0};
        pos_nxt  = pos_r + POSITION_WIDTH'(1);
        if (word_r[15]) begin
          code_nxt  = code.bytes;
          rem_nxt   = code.last_idx;
          more_nxt  = |word_r[14:0];
          last_nxt  = pos_r;
          state_nxt = S_EMIT;
        end else if (word_r[14:0] == 15'h0) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          end_nxt       = (rem_r == 2'd0);
          lor_nxt       = (rem_r == 2'd0) && !more_r;
          case (rem_r)
            2'd0:    byte_nxt = code_r[7:0];
            2'd1:    byte_nxt = code_r[15:8];
            2'd2:    byte_nxt = code_r[23:16];
            default: byte_nxt = code_r[31:24];
          endcase
          if (rem_r == 2'd0) begin
            state_nxt = more_r ? S_SCAN : S_IDLE;
          end else begin
            rem_nxt = rem_r - 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `FDCE_ASSERT(a_run_end_on_code_end, out_valid && out_last_of_run |-> out_code_end,
               "last byte of a word is not the end of a code")
  `FDCE_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready,
               "input taken again right after a transfer")
  `FDCE_ASSERT(a_code_tail_pending, out_valid && !out_code_end |-> state_r == S_EMIT,
               "code bytes left behind while sequencer moved on")
  `FDCE_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid,
                      "output valid after reset")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench
  import fdce_pkg::*;
();

  localparam int PW = POS_WIDTH_DEF;

  typedef struct packed {
    logic [7:0] code;
    logic       code_end;
    logic       last_of_run;
  } code_beat_t;

  typedef struct packed {
    logic [15:0] flux;
    logic        start;
    logic [11:0] reps;
    logic        typed;
    logic [7:0]  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_flux_word;
  logic        in_track_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_code_byte;
  logic        out_code_end;
  logic        out_last_of_run;

  logic [PW-1:0] scan_pos;
  logic [PW-1:0] prev_pulse;
  code_beat_t    word_codes[$];
  code_beat_t    awaited_codes[$];
  stim_row_t     plan [17];

  int unsigned fail_count = 0;
  int unsigned idle_pct = 0;
  bit          hold_off_req = 1'b0;

  flux_delta_code_encoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_flux_word    (in_flux_word),
    .in_track_start  (in_track_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_byte   (out_code_byte),
    .out_code_end    (out_code_end),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  function automatic void push_code(input logic [7:0] b, input logic fin);
    code_beat_t beat;
    beat.code        = b;
    beat.code_end    = fin;
    beat.last_of_run = 1'b0;
    word_codes.push_back(beat);
  endfunction

  function automatic void encode_gap(input logic [31:0] gap);
    if (gap < LIM_1B) begin
      push_code(gap[7:0], 1'b1);
    end else if (gap < LIM_2B) begin
      push_code(PFX_2B | gap[15:8], 1'b0);
      push_code(gap[7:0], 1'b1);
    end else if (gap < LIM_3B) begin
      push_code(PFX_3B | gap[23:16], 1'b0);
      push_code(gap[15:8], 1'b0);
      push_code(gap[7:0], 1'b1);
    end else if (gap < LIM_4B) begin
      push_code(PFX_4B | gap[31:24], 1'b0);
      push_code(gap[23:16], 1'b0);
      push_code(gap[15:8], 1'b0);
      push_code(gap[7:0], 1'b1);
    end else begin
      push_code(CODE_SAT[31:24], 1'b0);
      push_code(CODE_SAT[23:16], 1'b0);
      push_code(CODE_SAT[15:8], 1'b0);
      push_code(CODE_SAT[7:0], 1'b1);
    end
  endfunction

  function automatic void encode_flux_word(input logic [15:0] word, input logic start);
    logic [PW-1:0] pulse_at;
    code_beat_t    tail;
    word_codes.delete();
    if (start) begin
      scan_pos   = '0;
      prev_pulse = '0;
    end
    for (int i = 0; i < 16; i++) begin
      if (word[15-i]) begin
        pulse_at = scan_pos + PW'(i);
        encode_gap(32'(pulse_at - prev_pulse));
        prev_pulse = pulse_at;
      end
    end
    scan_pos = scan_pos + PW'(16);
    if (word_codes.size() != 0) begin
      tail = word_codes[word_codes.size()-1];
      tail.last_of_run = 1'b1;
      word_codes[word_codes.size()-1] = tail;
    end
  endfunction

  task automatic offer_word(input logic [15:0] word, input logic start,
                            input logic typed, input logic [7:0] want);
    code_beat_t beat;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_flux_word   <= word;
    in_track_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_flux_word(word, start);
    if (typed) begin
      beat.code        = want;
      beat.code_end    = 1'b1;
      beat.last_of_run = 1'b1;
      awaited_codes.push_back(beat);
    end else begin
      foreach (word_codes[k]) awaited_codes.push_back(word_codes[k]);
    end
  endtask

  always @(posedge clk) begin : check_codes
    code_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_codes.size() == 0) begin
        $display("%0t: unexpected transfer code_byte %02h code_end %0b last_of_run %0b",
                 $time, out_code_byte, out_code_end, out_last_of_run);
        fail_count++;
      end else begin
        exp_beat = awaited_codes.pop_front();
        if (out_code_byte !== exp_beat.code) begin
          $display("%0t: code_byte expected %02h actual %02h",
                   $time, exp_beat.code, out_code_byte);
          fail_count++;
        end
        if (out_code_end !== exp_beat.code_end) begin
          $display("%0t: code_end expected %0b actual %0b",
                   $time, exp_beat.code_end, out_code_end);
          fail_count++;
        end
        if (out_last_of_run !== exp_beat.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, exp_beat.last_of_run, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin
    bit hold_served;
    hold_served = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #40_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    bit          hold_issued;
    bit          long_gap_done;
    logic [15:0] word;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_flux_word   <= 16'h0000;
    in_track_start <= 1'b0;
    scan_pos      = '0;
    prev_pulse    = '0;
    sent          = 0;
    hold_issued   = 1'b0;
    long_gap_done = 1'b0;

    plan = '{
      '{16'h8000, 1'b1, 12'd1,    1'b1, 8'h00},
      '{16'h0001, 1'b0, 12'd1,    1'b1, 8'h1F},
      '{16'hFFFF, 1'b0, 12'd1,    1'b0, 8'h00},
      '{16'h0000, 1'b0, 12'd3,    1'b0, 8'h00},
      '{16'h8000, 1'b1, 12'd1,    1'b1, 8'h00},
      '{16'h0000, 1'b0, 12'd6,    1'b0, 8'h00},
      '{16'h0001, 1'b0, 12'd1,    1'b1, 8'h7F},
      '{16'h0000, 1'b0, 12'd7,    1'b0, 8'h00},
      '{16'h0001, 1'b0, 12'd1,    1'b0, 8'h00},
      '{16'h8000, 1'b1, 12'd1,    1'b1, 8'h00},
      '{16'hAAAA, 1'b0, 12'd1,    1'b0, 8'h00},
      '{16'h5555, 1'b1, 12'd1,    1'b0, 8'h00},
      '{16'h8001, 1'b0, 12'd1,    1'b0, 8'h00},
      '{16'h0000, 1'b1, 12'd1,    1'b0, 8'h00},
      '{16'h4000, 1'b0, 12'd1,    1'b0, 8'h00},
      '{16'hFFFF, 1'b1, 12'd1,    1'b0, 8'h00},
      '{16'h7FFE, 1'b0, 12'd1,    1'b0, 8'h00}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 25;
    foreach (plan[r]) begin
      repeat (plan[r].reps)
        offer_word(plan[r].flux, plan[r].start, plan[r].typed, plan[r].want);
    end

    while (sent < 370) begin
      idle_pct = (sent < 100) ? 25 : (sent < 200) ? 0 : (sent < 330) ? 60 : 0;
      if (sent >= 100 && !hold_issued) begin
        hold_issued  = 1'b1;
        hold_off_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        burst = $urandom_range(1, 12);
        repeat (burst) offer_word(16'h0000, 1'b0, 1'b0, 8'h00);
        sent += burst;
      end else begin
        if (pick < 60) begin
          word = 16'h0000;
          repeat ($urandom_range(1, 3)) word[$urandom_range(0, 15)] = 1'b1;
        end else if (pick < 80) begin
          word = 16'($urandom);
        end else if (pick < 85) begin
          word = 16'hFFFF;
        end else begin
          word = 16'($urandom) & 16'($urandom);
        end
        offer_word(word, ($urandom_range(0, 19) == 0), 1'b0, 8'h00);
        sent++;
      end
      if (sent >= 200 && !long_gap_done) begin
        long_gap_done = 1'b1;
        burst = $urandom_range(8, 40);
        repeat (burst) offer_word(16'h0000, 1'b0, 1'b0, 8'h00);
        offer_word(16'h0001 << $urandom_range(0, 15), 1'b0, 1'b0, 8'h00);
        sent += burst + 1;
      end
    end

    in_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> flux_delta_code_encoder_core.f
+incdir+rtl/core
rtl/core/fdce_pkg.sv
rtl/core/fdce_delta_code.sv
rtl/core/flux_delta_code_encoder_core.sv
tb/testbench.sv
